@@ hdl/irpd_pkg.sv @@
package irpd_pkg;

  // Timer stamp width and edge count limit
  localparam int unsigned STAMP_BITS = 16;
  localparam int unsigned MAX_EDGES  = 100;
  localparam int unsigned COUNT_BITS = $clog2(MAX_EDGES);

  // Frame layout
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned POS_BITS       = $clog2(WORD_BITS);
  localparam int unsigned FIRST_BIT_EDGE = 2;
  localparam int unsigned LAST_BIT_EDGE  = FIRST_BIT_EDGE + WORD_BITS;

  // Configuration register widths
  localparam int unsigned THRESH_BITS = 16;
  localparam int unsigned EDGE_BITS   = 7;
  localparam int unsigned CFG_DATA_BITS = THRESH_BITS;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CODE_BITS     = 16;

  // Compare width covering both stamp differences and thresholds
  localparam int unsigned CMP_BITS =
    (STAMP_BITS > THRESH_BITS) ? STAMP_BITS : THRESH_BITS;

  // Reset values of the configuration registers
  localparam logic [THRESH_BITS-1:0] BIT_THRESH_RST    = THRESH_BITS'(1200);
  localparam logic [THRESH_BITS-1:0] LEADER_THRESH_RST = THRESH_BITS'(7000);
  localparam logic [EDGE_BITS-1:0]   LEADER_WINDOW_RST = EDGE_BITS'(10);
  localparam logic [EDGE_BITS-1:0]   FRAME_EDGES_RST   = EDGE_BITS'(36);

  // Register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BIT_THRESH    = 2'd0,
    CFG_LEADER_THRESH = 2'd1,
    CFG_LEADER_WINDOW = 2'd2,
    CFG_FRAME_EDGES   = 2'd3
  } irpd_cfg_idx_e;

  // One decoded frame
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [WORD_BITS-1:0] raw_word;
    logic                 check_failed;
  } irpd_result_t;

  // Core to output stage
  typedef struct packed {
    logic         push;
    irpd_result_t res;
  } irpd_push_t;

endpackage

@@ hdl/irpd_core.sv @@
module irpd_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [irpd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [irpd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 rising_i,
  input  logic [irpd_pkg::STAMP_BITS-1:0]      stamp_i,
  input  logic                                 out_space_i,
  output irpd_pkg::irpd_push_t                 push_o
);

  // Configuration registers
  logic [irpd_pkg::THRESH_BITS-1:0] bit_thresh_q, leader_thresh_q;
  logic [irpd_pkg::EDGE_BITS-1:0]   leader_window_q, frame_edges_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_thresh_q    <= irpd_pkg::BIT_THRESH_RST;
      leader_thresh_q <= irpd_pkg::LEADER_THRESH_RST;
      leader_window_q <= irpd_pkg::LEADER_WINDOW_RST;
      frame_edges_q   <= irpd_pkg::FRAME_EDGES_RST;
    end else if (cfg_we_i) begin
      unique case (irpd_pkg::irpd_cfg_idx_e'(cfg_idx_i))
        irpd_pkg::CFG_BIT_THRESH:    bit_thresh_q    <= cfg_data_i;
        irpd_pkg::CFG_LEADER_THRESH: leader_thresh_q <= cfg_data_i;
        irpd_pkg::CFG_LEADER_WINDOW: leader_window_q <= cfg_data_i[irpd_pkg::EDGE_BITS-1:0];
        irpd_pkg::CFG_FRAME_EDGES:   frame_edges_q   <= cfg_data_i[irpd_pkg::EDGE_BITS-1:0];
      endcase
    end
  end

  // Input register
  logic                            in_valid_q;
  logic                            rising_q;
  logic [irpd_pkg::STAMP_BITS-1:0] stamp_q;
  logic                            advance;

  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rising_q <= rising_i;
      stamp_q  <= stamp_i;
    end
  end

  // Decoder state
  logic [irpd_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic [irpd_pkg::STAMP_BITS-1:0] fall_q, fall_d, rise_q, rise_d;
  logic [irpd_pkg::WORD_BITS-1:0]  word_q, word_d;

  logic [irpd_pkg::STAMP_BITS-1:0] space, pulse;
  logic [irpd_pkg::COUNT_BITS-1:0] pos_full, cnt_lead, cnt_inc;
  logic [irpd_pkg::POS_BITS-1:0]   pos;
  logic                            in_bit_range, is_leader, frame_done, check_ok;
  irpd_pkg::irpd_result_t          res;

  assign space    = stamp_q - rise_q;
  assign pulse    = stamp_q - fall_q;
  assign pos_full = count_q - irpd_pkg::COUNT_BITS'(irpd_pkg::FIRST_BIT_EDGE);
  assign pos      = pos_full[irpd_pkg::POS_BITS-1:0];

  assign in_bit_range = (count_q >= irpd_pkg::COUNT_BITS'(irpd_pkg::FIRST_BIT_EDGE)) &&
                        (count_q <  irpd_pkg::COUNT_BITS'(irpd_pkg::LAST_BIT_EDGE));

  // Leader restart, then saturating increment
  assign is_leader = (irpd_pkg::CMP_BITS'(pulse) > irpd_pkg::CMP_BITS'(leader_thresh_q)) &&
                     (irpd_pkg::EDGE_BITS'(count_q) < leader_window_q);
  assign cnt_lead  = is_leader ? '0 : count_q;
  assign cnt_inc   = (cnt_lead < irpd_pkg::COUNT_BITS'(irpd_pkg::MAX_EDGES - 1)) ?
                     cnt_lead + irpd_pkg::COUNT_BITS'(1) : cnt_lead;
  assign frame_done = rising_q && (irpd_pkg::EDGE_BITS'(cnt_inc) >= frame_edges_q);

  // Frame check: byte 1 and byte 3 are complements of byte 0 and byte 2
  assign check_ok = (word_q[7:0]   == ~word_q[15:8]) &&
                    (word_q[23:16] == ~word_q[31:24]);

  always_comb begin
    res.code         = check_ok ? {word_q[7:0], word_q[23:16]} : '0;
    res.raw_word     = word_q;
    res.check_failed = !check_ok;
  end

  // Item proceeds unless a result would find the output stage full
  assign advance = in_valid_q && (out_space_i || !frame_done);

  always_comb begin
    push_o.push = advance && frame_done;
    push_o.res  = res;
  end

  // State update for one edge
  always_comb begin
    count_d = count_q;
    fall_d  = fall_q;
    rise_d  = rise_q;
    word_d  = word_q;
    if (advance) begin
      if (!rising_q) begin
        fall_d = stamp_q;
        if (in_bit_range) begin
          word_d[pos] = irpd_pkg::CMP_BITS'(space) > irpd_pkg::CMP_BITS'(bit_thresh_q);
        end
      end else begin
        rise_d  = stamp_q;
        count_d = frame_done ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fall_q  <= '0;
      rise_q  <= '0;
      word_q  <= '0;
    end else begin
      count_q <= count_d;
      fall_q  <= fall_d;
      rise_q  <= rise_d;
      word_q  <= word_d;
    end
  end

  // Count saturates below the limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= irpd_pkg::COUNT_BITS'(irpd_pkg::MAX_EDGES - 1))
    else $error("edge count beyond limit");

  // A completed frame clears the count
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |=> count_q == '0)
    else $error("count not cleared after frame");

  // A held item is not lost
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(stamp_q) && $stable(rising_q)))
    else $error("stalled item dropped");

endmodule

@@ hdl/irpd_out.sv @@
module irpd_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  irpd_pkg::irpd_push_t   push_i,
  output logic                   out_space_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output irpd_pkg::irpd_result_t res_o
);

  logic                   valid_q, valid_d;
  irpd_pkg::irpd_result_t res_q;

  // Room when empty or the held item leaves this cycle
  assign out_space_o = !valid_q || out_ready_i;
  assign valid_d     = push_i.push || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      res_q <= push_i.res;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.push && valid_q && !out_ready_i))
    else $error("result overwritten");

endmodule

@@ hdl/ir_pulse_distance_decoder_unit.sv @@
// IR pulse-distance (NEC style) decoder. Each input item is one edge of the
// receiver line: its direction and a wrapping timer stamp. Falling edges 2..33
// of a frame decode one bit each from the space since the previous rising
// edge; a long low pulse early in a frame restarts the edge count. On the
// rising edge that brings the count to frame_edges, one item is delivered:
// the address/command code (zero on a failed complement check), the raw
// 32-bit word and the check flag. Throughput is one edge per clock. The
// completing edge is captured in the input register, and the state update
// then loads the result register, from which the result is offered. The
// block stalls input only while a result waits and the next edge would
// complete another frame. Configuration writes take effect at once and
// belong to idle times.
module ir_pulse_distance_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [irpd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [irpd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               rising_i,
  input  logic [irpd_pkg::STAMP_BITS-1:0]    stamp_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [irpd_pkg::CODE_BITS-1:0]     code_o,
  output logic [irpd_pkg::WORD_BITS-1:0]     raw_word_o,
  output logic                               check_failed_o
);

  irpd_pkg::irpd_push_t   push;
  irpd_pkg::irpd_result_t res;
  logic                   out_space;

  // Edge decoding and frame state
  irpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rising_i    (rising_i),
    .stamp_i     (stamp_i),
    .out_space_i (out_space),
    .push_o      (push)
  );

  // Result register
  irpd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_space_o (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign code_o         = res.code;
  assign raw_word_o     = res.raw_word;
  assign check_failed_o = res.check_failed;

endmodule
